// ===== hdl/pac_pkg.sv =====
package pac_pkg;

  // signed working width for clipped bounds and pixel coordinates
  localparam int CW = 15;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [1:0]           mode_t;
  typedef logic [2:0]           reg_idx_t;

  localparam mode_t MODE_OUTLINE = 2'd0;
  localparam mode_t MODE_FILL    = 2'd1;
  localparam mode_t MODE_PATTERN = 2'd2;
  localparam mode_t MODE_OVERLAY = 2'd3;

  localparam reg_idx_t REG_MODE   = 3'd0;
  localparam reg_idx_t REG_TOP    = 3'd1;
  localparam reg_idx_t REG_LEFT   = 3'd2;
  localparam reg_idx_t REG_BOTTOM = 3'd3;
  localparam reg_idx_t REG_RIGHT  = 3'd4;
  localparam reg_idx_t REG_COLOR  = 3'd5;
  localparam reg_idx_t REG_WIDTH  = 3'd6;
  localparam reg_idx_t REG_HEIGHT = 3'd7;

  localparam logic [12:0] DIM_RESET = 13'd4096;

  typedef struct packed {
    mode_t              mode;
    logic signed [12:0] top;
    logic signed [12:0] left;
    logic signed [13:0] bottom;
    logic signed [13:0] right;
    logic [23:0]        color;
    logic [12:0]        width;
    logic [12:0]        height;
  } cfg_t;

  typedef struct packed {
    coord_t r0;
    coord_t c0;
    coord_t r1;
    coord_t c1;
    logic   empty;
  } region_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  dr;
    logic [7:0]  dg;
    logic [7:0]  db;
    logic [7:0]  sr;
    logic [7:0]  sg;
    logic [7:0]  sb;
    logic        pbit;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       written;
  } res_t;

endpackage

// ===== hdl/pac_cfg_regs.sv =====
module pac_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  pac_pkg::reg_idx_t wr_idx,
  input  logic [23:0]       wr_data,
  output pac_pkg::cfg_t     cfg
);
  import pac_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_MODE:   cfg_nxt.mode   = wr_data[1:0];
        REG_TOP:    cfg_nxt.top    = signed'(wr_data[12:0]);
        REG_LEFT:   cfg_nxt.left   = signed'(wr_data[12:0]);
        REG_BOTTOM: cfg_nxt.bottom = signed'(wr_data[13:0]);
        REG_RIGHT:  cfg_nxt.right  = signed'(wr_data[13:0]);
        REG_COLOR:  cfg_nxt.color  = wr_data;
        REG_WIDTH:  cfg_nxt.width  = wr_data[12:0];
        REG_HEIGHT: cfg_nxt.height = wr_data[12:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_OUTLINE;
      cfg_r.top    <= '0;
      cfg_r.left   <= '0;
      cfg_r.bottom <= '0;
      cfg_r.right  <= '0;
      cfg_r.color  <= '0;
      cfg_r.width  <= DIM_RESET;
      cfg_r.height <= DIM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/pac_clip.sv =====
module pac_clip (
  input  pac_pkg::cfg_t    cfg,
  input  logic [12:0]      width_lim,
  input  logic [12:0]      height_lim,
  output pac_pkg::region_t region
);
  import pac_pkg::*;

  coord_t top_x;
  coord_t left_x;
  coord_t bottom_x;
  coord_t right_x;
  coord_t w_last;
  coord_t h_last;

  always_comb begin
    top_x    = CW'(cfg.top);
    left_x   = CW'(cfg.left);
    bottom_x = CW'(cfg.bottom);
    right_x  = CW'(cfg.right);
    // last valid row / column; -1 for a zero-size image
    w_last   = signed'({2'b00, width_lim}) - coord_t'(1);
    h_last   = signed'({2'b00, height_lim}) - coord_t'(1);

    region.r0    = (top_x < 0) ? '0 : top_x;
    region.c0    = (left_x < 0) ? '0 : left_x;
    region.r1    = (bottom_x > h_last) ? h_last : bottom_x;
    region.c1    = (right_x > w_last) ? w_last : right_x;
    region.empty = (region.r0 > region.r1) || (region.c0 > region.c1);
  end

endmodule

// ===== hdl/pac_pixel.sv =====
module pac_pixel (
  input  pac_pkg::mode_t   mode,
  input  logic [23:0]      color,
  input  pac_pkg::region_t region,
  input  pac_pkg::pix_t    pix,
  output pac_pkg::res_t    res
);
  import pac_pkg::*;

  coord_t row_x;
  coord_t col_x;
  logic   in_region;
  logic   on_edge;
  logic   key_hit;
  logic   paint;
  logic   copy_src;

  always_comb begin
    row_x   = signed'({3'b000, pix.row});
    col_x   = signed'({3'b000, pix.col});
    in_region = !region.empty &&
                row_x >= region.r0 && row_x <= region.r1 &&
                col_x >= region.c0 && col_x <= region.c1;
    on_edge = row_x == region.r0 || row_x == region.r1 ||
              col_x == region.c0 || col_x == region.c1;
    key_hit = {pix.sr, pix.sg, pix.sb} == color;

    paint    = 1'b0;
    copy_src = 1'b0;
    if (in_region) begin
      unique case (mode)
        MODE_OUTLINE: paint    = on_edge;
        MODE_FILL:    paint    = 1'b1;
        MODE_PATTERN: paint    = pix.pbit;
        MODE_OVERLAY: copy_src = !key_hit;
      endcase
    end

    if (paint) begin
      {res.red, res.green, res.blue} = color;
    end else if (copy_src) begin
      {res.red, res.green, res.blue} = {pix.sr, pix.sg, pix.sb};
    end else begin
      {res.red, res.green, res.blue} = {pix.dr, pix.dg, pix.db};
    end
    res.written = paint || copy_src;
  end

endmodule

// ===== hdl/pixel_annotation_compositor.sv =====
// an accepted word is captured in the input register, then its result in the result register,
// which drives out_* with out_valid
// throughput: one pixel per clock, back to back; busy is low except during reset and the
// first cycle after it
// the result strobe is a one-cycle pulse; the receiver cannot stall
// reset (rst_n low, synchronous) restores register defaults (image 4096 x 4096,
// all else zero), drops any pixel in flight and holds busy high
module pixel_annotation_compositor #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,

  // pixel input, command style
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_pixel_row,
  input  logic [11:0] in_pixel_col,
  input  logic [7:0]  in_dst_red,
  input  logic [7:0]  in_dst_green,
  input  logic [7:0]  in_dst_blue,
  input  logic [7:0]  in_src_red,
  input  logic [7:0]  in_src_green,
  input  logic [7:0]  in_src_blue,
  input  logic        in_pattern_bit,

  // result strobe
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_was_written,

  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import pac_pkg::*;

  // largest image dimension the 13-bit size registers can name
  localparam int          DimRegMax = 8191;
  localparam logic [12:0] DimCap    = (MAX_DIM > DimRegMax) ? 13'(DimRegMax) : 13'(MAX_DIM);

  logic    busy_r;
  logic    accept;

  pix_t    pix_r;
  pix_t    pix_nxt;
  logic    pix_vld_r;

  res_t    res_r;
  res_t    res_nxt;
  logic    res_vld_r;

  cfg_t    cfg;
  region_t region;
  logic [12:0] width_lim;
  logic [12:0] height_lim;

  // registers are always writable; software must only write between frames, which the block does not enforce
  assign cfg_ready = 1'b1;

  pac_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // sizes above MAX_DIM are treated as MAX_DIM
  assign width_lim  = (32'(cfg.width) > 32'(DimCap)) ? DimCap : cfg.width;
  assign height_lim = (32'(cfg.height) > 32'(DimCap)) ? DimCap : cfg.height;

  // clipped region is combinational and depends only on registers
  pac_clip u_clip (
    .cfg        (cfg),
    .width_lim  (width_lim),
    .height_lim (height_lim),
    .region     (region)
  );

  // busy only covers the reset window; the datapath takes a word every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // input register
  always_comb begin
    pix_nxt.row  = in_pixel_row;
    pix_nxt.col  = in_pixel_col;
    pix_nxt.dr   = in_dst_red;
    pix_nxt.dg   = in_dst_green;
    pix_nxt.db   = in_dst_blue;
    pix_nxt.sr   = in_src_red;
    pix_nxt.sg   = in_src_green;
    pix_nxt.sb   = in_src_blue;
    pix_nxt.pbit = in_pattern_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
    end else begin
      pix_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= pix_nxt;
    end
  end

  // per-pixel compare and select
  pac_pixel u_pixel (
    .mode   (cfg.mode),
    .color  (cfg.color),
    .region (region),
    .pix    (pix_r),
    .res    (res_nxt)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= pix_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_vld_r;
  assign out_red         = res_r.red;
  assign out_green       = res_r.green;
  assign out_blue        = res_r.blue;
  assign out_was_written = res_r.written;

  // a result strobe always traces back to an accepted word, through the input and result registers
  a_strobe_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result strobe without a matching accepted word");

  // an untouched pixel carries its destination color through unchanged
  a_pass_through_color : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_was_written) |->
      (out_red == $past(in_dst_red, 2) && out_green == $past(in_dst_green, 2) &&
       out_blue == $past(in_dst_blue, 2)))
    else $error("unwritten pixel lost its destination color");

  // nothing can be written while the clipped region is empty
  a_empty_region_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (pix_vld_r && region.empty) |-> !res_nxt.written)
    else $error("pixel written with an empty clipped region");

endmodule
